// ===== rtl/float_sort_engine_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the float sort engine
// Implication checks, same-cycle and next-cycle forms
// ---------------------------------------------------------------------------
`ifndef FLOAT_SORT_ENGINE_CORE_ASSERT_SVH
`define FLOAT_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define FSE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fse assertion failed");

// next-cycle implication
`define FSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fse assertion failed");

`endif

// ===== rtl/fse_pkg.sv =====
// ---------------------------------------------------------------------------
// fse_pkg
// Shared constants, types and the ordering key of the sort engine
// ---------------------------------------------------------------------------
package fse_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic load;   // insert broadcast word
      logic shift;  // move one place toward cell 0
   } cell_ctl_type;

   function automatic logic [31:0] order_key(input logic [31:0] bits);
      order_key = bits[31] ? ~bits : (bits | 32'h8000_0000);
   endfunction

endpackage

// ===== rtl/fse_if.sv =====
// ---------------------------------------------------------------------------
// fse request / response interfaces
// Valid/ready channels carrying input and sorted words
// ---------------------------------------------------------------------------
interface fse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        last_item;
   modport source (output valid, value, last_item, input ready);
   modport sink   (input valid, value, last_item, output ready);
endinterface

interface fse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sorted_value;
   logic        last_out;
   logic        overflow;
   modport source (output valid, sorted_value, last_out, overflow, input ready);
   modport sink   (input valid, sorted_value, last_out, overflow, output ready);
endinterface

// ===== rtl/fse_cell.sv =====
// ---------------------------------------------------------------------------
// fse_cell
// One insertion cell: holds a word, inserts or shifts toward the head
// ---------------------------------------------------------------------------
module fse_cell
   import fse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic [31:0]  new_value,
   input  logic         head,        // cell 0: no left neighbor
   input  logic [31:0]  left_value,
   input  logic         left_valid,
   input  logic         left_gt,
   input  logic [31:0]  right_value,
   input  logic         right_valid,
   output logic [31:0]  value,
   output logic         valid,
   output logic         gt
);

   logic [31:0] value_ff, value_in;
   logic        valid_ff, valid_in;

   // empty cell counts as +inf
   assign gt = !valid_ff || (order_key(value_ff) > order_key(new_value));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.load && gt) begin
         if (!head && left_gt) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end else if (ctl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/float_sort_engine_core.sv =====
// ---------------------------------------------------------------------------
// float_sort_engine_core
// Ascending sort of IEEE single words through a chain of insertion cells
// ---------------------------------------------------------------------------
// channel   dir  payload                           handshake
// req_chan  in   value[31:0], last_item            valid/ready
// rsp_chan  out  sorted_value[31:0], last_out,     valid/ready
//                overflow
//
// Loading takes one word per cycle; the word is inserted in place across the
// cell row. After the last word the set drains from cell 0, one word per cycle
// while rsp ready is high; req ready is low while draining.
// Reset is synchronous and empties all cells. rsp stalls hold the head cell.
// ---------------------------------------------------------------------------
`include "float_sort_engine_core_assert.svh"

module float_sort_engine_core
   import fse_pkg::*;
(
   input logic     clock,
   input logic     reset,
   fse_req_if.sink   req_chan,
   fse_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   cnt_type      cnt_ff, cnt_in;
   logic         ovf_ff, ovf_in;
   cell_ctl_type ctl;
   logic         req_acc, rsp_acc, room;

   logic [31:0] cval [MAX_ITEMS];
   logic        cvld [MAX_ITEMS];
   logic        cgt  [MAX_ITEMS];

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == ST_DRAIN);
   assign rsp_acc        = rsp_chan.valid && rsp_chan.ready;
   assign room           = (cnt_ff != cnt_type'(MAX_ITEMS));

   assign ctl.load  = req_acc && room;
   assign ctl.shift = rsp_acc;

   genvar g;
   generate
      for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
         fse_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .new_value   (req_chan.value),
            .head        (g == 0),
            .left_value  (cval[(g == 0) ? 0 : g - 1]),
            .left_valid  (cvld[(g == 0) ? 0 : g - 1]),
            .left_gt     (cgt[(g == 0) ? 0 : g - 1]),
            .right_value ((g == MAX_ITEMS - 1) ? 32'h0 : cval[(g == MAX_ITEMS - 1) ? g : g + 1]),
            .right_valid ((g == MAX_ITEMS - 1) ? 1'b0 : cvld[(g == MAX_ITEMS - 1) ? g : g + 1]),
            .value       (cval[g]),
            .valid       (cvld[g]),
            .gt          (cgt[g])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (room) cnt_in = cnt_ff + cnt_type'(1);
               else      ovf_in = 1'b1;
               if (req_chan.last_item) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_acc) begin
               cnt_in = cnt_ff - cnt_type'(1);
               if (cnt_ff == cnt_type'(1)) begin
                  state_in = ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_chan.sorted_value = cval[0];
   assign rsp_chan.last_out     = (cnt_ff == cnt_type'(1));
   assign rsp_chan.overflow     = ovf_ff;

   `FSE_ASSERT_NOW(a_rsp_has_word, clock, reset, rsp_chan.valid, cvld[0] && cnt_ff != '0)
   `FSE_ASSERT_NOW(a_drain_blocks, clock, reset, state_ff == ST_DRAIN, !req_chan.ready)
   `FSE_ASSERT_NEXT(a_last_ends_set, clock, reset, rsp_acc && rsp_chan.last_out, state_ff == ST_LOAD && cnt_ff == '0 && !ovf_ff)
   `FSE_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= cnt_type'(MAX_ITEMS))

endmodule

// ===== sim/fse_tb_if.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fse testbench channel notes
// The channel interfaces come from the RTL; this file holds the word types
// shared by the stimulus and checking code of the testbench.
// ---------------------------------------------------------------------------
package fse_tb_pkg;

   typedef struct {
      logic [31:0] value;
      logic        last_item;
   } req_word_type;

   typedef struct {
      logic [31:0] sorted_value;
      logic        last_out;
      logic        overflow;
   } rsp_word_type;

endpackage

// ===== sim/tb_float_sort_engine_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_float_sort_engine_core
// Drives sets of IEEE single words into the sort engine, predicts the sorted
// output with an insertion sort on the ordering key, and checks every word.
// ---------------------------------------------------------------------------
module tb_float_sort_engine_core;
   import fse_pkg::*;
   import fse_tb_pkg::*;

   localparam int LIMIT = fse_pkg::MAX_ITEMS;

   logic clock;
   logic reset;

   fse_req_if req_chan ();
   fse_rsp_if rsp_chan ();

   float_sort_engine_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   req_word_type pending_words[$];
   rsp_word_type sorted_expect[$];
   logic [31:0]  open_set[$];
   bit           open_overflow;
   int           error_count;
   int           hold_cycles;
   bit           pause_driver;
   bit           req_taken;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] sort_key(input logic [31:0] bits);
      return bits[31] ? ~bits : (bits | 32'h8000_0000);
   endfunction

   // mirror of the engine state on every accepted word
   task automatic predict_word(input req_word_type w);
      logic [31:0] v;
      int          j;
      if (open_set.size() < LIMIT) open_set.push_back(w.value);
      else open_overflow = 1'b1;
      if (w.last_item) begin
         for (int i = 1; i < open_set.size(); i++) begin
            v = open_set[i];
            j = i;
            while (j > 0 && sort_key(open_set[j-1]) > sort_key(v)) begin
               open_set[j] = open_set[j-1];
               j--;
            end
            open_set[j] = v;
         end
         for (int i = 0; i < open_set.size(); i++)
            sorted_expect.push_back('{open_set[i], i == open_set.size() - 1,
                                      open_overflow});
         open_set.delete();
         open_overflow = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   function automatic logic [31:0] rand_float();
      case ($urandom_range(0, 5))
         0: return {$urandom_range(0, 1) == 1, 31'h0};
         1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'h0};
         2: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 254)),
                          23'($urandom)};
      endcase
   endfunction

   task automatic add_set(input int n);
      for (int i = 0; i < n; i++) pending_words.push_back('{rand_float(), i == n - 1});
   endtask

   // driver
   int drive_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.value     <= '0;
         req_chan.last_item <= 1'b0;
         drive_gap = 0;
      end else begin
         if (!req_chan.valid || req_taken) begin
            if (drive_gap > 0) drive_gap--;
            if (drive_gap == 0 && pending_words.size() > 0 && !pause_driver) begin
               req_chan.valid     <= 1'b1;
               req_chan.value     <= pending_words[0].value;
               req_chan.last_item <= pending_words[0].last_item;
               drive_gap = gap_len();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // stall on the result side
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
   end

   // monitor
   rsp_word_type want;
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            void'(pending_words.pop_front());
            predict_word('{req_chan.value, req_chan.last_item});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (sorted_expect.size() == 0)
               report_mismatch("unexpected word", rsp_chan.sorted_value, '0);
            else begin
               want = sorted_expect.pop_front();
               if (rsp_chan.sorted_value !== want.sorted_value)
                  report_mismatch("sorted_value", rsp_chan.sorted_value, want.sorted_value);
               if (rsp_chan.last_out !== want.last_out)
                  report_mismatch("last_out", 32'(rsp_chan.last_out), 32'(want.last_out));
               if (rsp_chan.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_chan.overflow), 32'(want.overflow));
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   int total;
   initial begin
      error_count   = 0;
      hold_cycles   = 0;
      pause_driver  = 1'b0;
      open_overflow = 1'b0;
      reset         = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: single word, zeros, infinities, denormals, extremes
      pending_words.push_back('{32'h0000_0000, 1'b1});
      pending_words.push_back('{32'h0000_0000, 1'b0});
      pending_words.push_back('{32'h8000_0000, 1'b0});
      pending_words.push_back('{32'h7F80_0000, 1'b0});
      pending_words.push_back('{32'hFF80_0000, 1'b0});
      pending_words.push_back('{32'h0000_0001, 1'b0});
      pending_words.push_back('{32'h8000_0001, 1'b0});
      pending_words.push_back('{32'h7F7F_FFFF, 1'b0});
      pending_words.push_back('{32'hFF7F_FFFF, 1'b0});
      pending_words.push_back('{32'h3F80_0000, 1'b0});
      pending_words.push_back('{32'h3F80_0000, 1'b0});
      pending_words.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_words.push_back('{32'hBF80_0000, 1'b1});
      wait (pending_words.size() == 0 && sorted_expect.size() == 0);

      // full set, then overflow with dropped words including the last one
      add_set(LIMIT);
      add_set(LIMIT + 3);
      // long receiver stall while sender keeps offering
      @(negedge clock) hold_cycles = 300;
      add_set(20);
      add_set(5);
      wait (pending_words.size() == 0 && sorted_expect.size() == 0);

      // sender paused with a set pending, then released
      pause_driver = 1'b1;
      add_set(7);
      repeat (40) @(negedge clock);
      pause_driver = 1'b0;

      total = 0;
      while (total < 24) begin
         case ($urandom_range(0, 9))
            0: begin add_set(1); total += 1; end
            default: begin
               int n;
               n = $urandom_range(2, 12);
               add_set(n);
               total += n;
            end
         endcase
      end
      wait (pending_words.size() == 0);
      wait (sorted_expect.size() == 0);
      repeat (LIMIT + 20) @(posedge clock);
      if (error_count == 0 && sorted_expect.size() == 0 && open_set.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
